// ----- sv/esc_pkg.sv -----
// shared types, constants and helpers for the environmental sensor compensation pipeline
// no dependencies
package esc_pkg;

  localparam int unsigned NumRegs   = 5;
  localparam int unsigned CfgIdxW   = 3;
  localparam int unsigned CfgDataW  = 64;
  localparam int unsigned DivSteps  = 32;
  localparam int unsigned TempLat   = 4;
  localparam int unsigned PressLat  = 43;
  localparam int unsigned HumLat    = 7;
  localparam int unsigned TotalLat  = TempLat + PressLat;

  localparam logic [31:0] HumFineOffset   = 32'd76800;
  localparam logic [31:0] HumClampMax     = 32'd419430400;
  localparam logic [31:0] PressFineOffset = 32'd64000;
  localparam logic [31:0] PressScale      = 32'd3125;
  localparam logic [31:0] PressRawBase    = 32'd1048576;

  typedef enum logic [CfgIdxW-1:0] {
    REG_TEMP        = 3'd0,
    REG_PRESS_LOW   = 3'd1,
    REG_PRESS_HIGH  = 3'd2,
    REG_PRESS_HUMID = 3'd3,
    REG_HUMID       = 3'd4
  } cfg_reg_e;

  // side band carried through the divider
  typedef struct packed {
    logic valid;
    logic dbl;
    logic fault;
  } div_side_t;

  function automatic logic [31:0] sra32(input logic [31:0] v, input int unsigned s);
    logic signed [31:0] sv;
    sv = $signed(v);
    return 32'(sv >>> s);
  endfunction

  function automatic logic [31:0] sx16(input logic [15:0] v);
    return {{16{v[15]}}, v};
  endfunction

endpackage

// ----- sv/env_sensor_compensation.sv -----
// top level: coefficient registers, temperature, pressure and humidity paths
// depends on esc_pkg, esc_temp, esc_press, esc_humid
// Compensation pipeline: one raw reading set may enter every clock cycle
// (busy_o stays low) and its results appear on done_o in the order they
// entered. The depth is set by the pressure path: four stages of
// temperature to the fine value, then the pressure scaling, a 32-stage
// pipelined divider with one quotient bit per stage, and the final
// correction. Temperature and humidity finish earlier and are delayed to
// line up with pressure. The receiver cannot stall; each result is valid
// for one cycle only. Coefficients are written through cfg_we_i/cfg_index_i
// and should change only while no reading is in flight.
module env_sensor_compensation import esc_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start_i,
  output logic                busy_o,
  input  logic [19:0]         raw_temperature_i,
  input  logic [19:0]         raw_pressure_i,
  input  logic [15:0]         raw_humidity_i,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_index_i,
  input  logic [CfgDataW-1:0] cfg_wdata_i,
  output logic                done_o,
  output logic signed [15:0]  temperature_centi_o,
  output logic [31:0]         pressure_pascal_o,
  output logic                pressure_fault_o,
  output logic [16:0]         humidity_q10_o
);

  logic [47:0] temp_coeffs_q;
  logic [63:0] press_low_q, press_high_q;
  logic [47:0] press_humid_q;
  logic [31:0] humid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      temp_coeffs_q <= '0;
      press_low_q   <= '0;
      press_high_q  <= '0;
      press_humid_q <= '0;
      humid_q       <= '0;
    end else if (cfg_we_i) begin
      case (cfg_reg_e'(cfg_index_i))
        REG_TEMP:        temp_coeffs_q <= cfg_wdata_i[47:0];
        REG_PRESS_LOW:   press_low_q   <= cfg_wdata_i;
        REG_PRESS_HIGH:  press_high_q  <= cfg_wdata_i;
        REG_PRESS_HUMID: press_humid_q <= cfg_wdata_i[47:0];
        REG_HUMID:       humid_q       <= cfg_wdata_i[31:0];
        default: ;
      endcase
    end
  end

  logic        t_valid;
  logic [31:0] fine;
  logic [19:0] rp;
  logic [15:0] rh;
  logic [15:0] t_centi;
  logic        p_valid, p_fault;
  logic [31:0] p_val;
  logic [16:0] hum;
  logic [15:0] tdly_q [PressLat];
  logic [16:0] hdly_q [PressLat-HumLat];

  assign busy_o = 1'b0;

  esc_temp u_temp (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .valid_i           (start_i & ~busy_o),
    .raw_temperature_i (raw_temperature_i),
    .raw_pressure_i    (raw_pressure_i),
    .raw_humidity_i    (raw_humidity_i),
    .temp_coeffs_i     (temp_coeffs_q),
    .valid_o           (t_valid),
    .fine_o            (fine),
    .raw_pressure_o    (rp),
    .raw_humidity_o    (rh),
    .temp_centi_o      (t_centi)
  );

  esc_press u_press (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .valid_i             (t_valid),
    .fine_i              (fine),
    .raw_pressure_i      (rp),
    .press_coeffs_low_i  (press_low_q),
    .press_coeffs_high_i (press_high_q),
    .p9_raw_i            (press_humid_q[15:0]),
    .valid_o             (p_valid),
    .pressure_o          (p_val),
    .fault_o             (p_fault)
  );

  esc_humid u_humid (
    .clk_i          (clk_i),
    .fine_i         (fine),
    .raw_humidity_i (rh),
    .humid_hi_i     (press_humid_q[47:16]),
    .humid_coeffs_i (humid_q),
    .humidity_o     (hum)
  );

  // delay temperature and humidity to the pressure result
  always_ff @(posedge clk_i) begin
    tdly_q[0] <= t_centi;
    for (int i = 1; i < PressLat; i++) begin
      tdly_q[i] <= tdly_q[i-1];
    end
    hdly_q[0] <= hum;
    for (int i = 1; i < PressLat - HumLat; i++) begin
      hdly_q[i] <= hdly_q[i-1];
    end
  end

  assign done_o              = p_valid;
  assign temperature_centi_o = tdly_q[PressLat-1];
  assign pressure_pascal_o   = p_val;
  assign pressure_fault_o    = p_fault;
  assign humidity_q10_o      = hdly_q[PressLat-HumLat-1];

`ifndef SYNTHESIS
  a_never_busy : assert property (@(posedge clk_i) disable iff (!rst_ni) !busy_o);

  a_done_known : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !$isunknown(done_o));

  a_fault_zero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && pressure_fault_o) |-> (pressure_pascal_o == '0));

  a_humid_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> ({15'b0, humidity_q10_o} <= (HumClampMax >> 12)));

  a_done_latency : assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(start_i, TotalLat));
`endif

endmodule

// ----- sv/esc_temp.sv -----
// temperature path: fine temperature and saturated hundredths of a degree
// depends on esc_pkg
module esc_temp import esc_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        valid_i,
  input  logic [19:0] raw_temperature_i,
  input  logic [19:0] raw_pressure_i,
  input  logic [15:0] raw_humidity_i,
  input  logic [47:0] temp_coeffs_i,
  output logic        valid_o,
  output logic [31:0] fine_o,
  output logic [19:0] raw_pressure_o,
  output logic [15:0] raw_humidity_o,
  output logic [15:0] temp_centi_o
);

  logic [31:0] t1, t2, t3;
  logic [TempLat-1:0] vld_q;
  logic [31:0] x1_q, d_q, m1_q, dd_q, a_q, m2_q, fine_q;
  logic [19:0] rp_q [TempLat];
  logic [15:0] rh_q [TempLat];
  logic [31:0] tm, t;

  assign t1 = {16'b0, temp_coeffs_i[15:0]};
  assign t2 = sx16(temp_coeffs_i[31:16]);
  assign t3 = sx16(temp_coeffs_i[47:32]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= {vld_q[TempLat-2:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    x1_q   <= {15'b0, raw_temperature_i[19:3]} - (t1 << 1);
    d_q    <= {16'b0, raw_temperature_i[19:4]} - t1;
    m1_q   <= x1_q * t2;
    dd_q   <= d_q * d_q;
    a_q    <= sra32(m1_q, 11);
    m2_q   <= sra32(dd_q, 12) * t3;
    fine_q <= a_q + sra32(m2_q, 14);
    rp_q[0] <= raw_pressure_i;
    rh_q[0] <= raw_humidity_i;
    for (int i = 1; i < TempLat; i++) begin
      rp_q[i] <= rp_q[i-1];
      rh_q[i] <= rh_q[i-1];
    end
  end

  // fine * 5 + 128, then divide by 256
  assign tm = (fine_q << 2) + fine_q + 32'd128;
  assign t  = sra32(tm, 8);

  always_comb begin
    if ($signed(t) < -32'sd32768) begin
      temp_centi_o = 16'h8000;
    end else if ($signed(t) > 32'sd32767) begin
      temp_centi_o = 16'h7fff;
    end else begin
      temp_centi_o = t[15:0];
    end
  end

  assign valid_o        = vld_q[TempLat-1];
  assign fine_o         = fine_q;
  assign raw_pressure_o = rp_q[TempLat-1];
  assign raw_humidity_o = rh_q[TempLat-1];

endmodule

// ----- sv/esc_div.sv -----
// pipelined restoring divider, one quotient bit per stage, unsigned 32 by 32
// depends on esc_pkg
module esc_div import esc_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic [31:0] dividend_i,
  input  logic [31:0] divisor_i,
  input  div_side_t   side_i,
  output logic [31:0] quot_o,
  output div_side_t   side_o
);

  logic [31:0] rem_q [DivSteps];
  logic [31:0] dvd_q [DivSteps];
  logic [31:0] dvs_q [DivSteps];
  logic [31:0] quo_q [DivSteps];
  div_side_t   sd_q  [DivSteps];

  for (genvar g = 0; g < DivSteps; g++) begin : g_step
    logic [31:0] rem_in, dvd_in, dvs_in, quo_in;
    div_side_t   sd_in;
    logic [32:0] trial, diff;

    if (g == 0) begin : g_first
      assign rem_in = '0;
      assign dvd_in = dividend_i;
      assign dvs_in = divisor_i;
      assign quo_in = '0;
      assign sd_in  = side_i;
    end else begin : g_next
      assign rem_in = rem_q[g-1];
      assign dvd_in = dvd_q[g-1];
      assign dvs_in = dvs_q[g-1];
      assign quo_in = quo_q[g-1];
      assign sd_in  = sd_q[g-1];
    end

    assign trial = {rem_in, dvd_in[31]};
    assign diff  = trial - {1'b0, dvs_in};

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        sd_q[g] <= '0;
      end else begin
        sd_q[g] <= sd_in;
      end
    end

    always_ff @(posedge clk_i) begin
      dvd_q[g]      <= dvd_in << 1;
      dvs_q[g]      <= dvs_in;
      if (!diff[32]) begin
        rem_q[g] <= diff[31:0];
        quo_q[g] <= {quo_in[30:0], 1'b1};
      end else begin
        rem_q[g] <= trial[31:0];
        quo_q[g] <= {quo_in[30:0], 1'b0};
      end
    end
  end

  assign quot_o = quo_q[DivSteps-1];
  assign side_o = sd_q[DivSteps-1];

endmodule

// ----- sv/esc_press.sv -----
// pressure path from fine temperature, divider included
// depends on esc_pkg and esc_div
module esc_press import esc_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        valid_i,
  input  logic [31:0] fine_i,
  input  logic [19:0] raw_pressure_i,
  input  logic [63:0] press_coeffs_low_i,
  input  logic [63:0] press_coeffs_high_i,
  input  logic [15:0] p9_raw_i,
  output logic        valid_o,
  output logic [31:0] pressure_o,
  output logic        fault_o
);

  logic [31:0] p1, p2, p3, p4, p5, p6, p7, p8, p9;
  logic [6:0]  vld_q;
  logic [31:0] pa_q, sq_q, m5_q, m2_q, b1_q, m3_q, m5b_q, m2b_q;
  logic [31:0] b_q, aa_q, m1_q, pre_q, dv_q, num_q, dvd_q, dvs_q;
  logic [19:0] rp_q [4];
  logic        dbl_q, flt_q;
  logic [31:0] quot;
  div_side_t   side_in, side_out;
  logic [3:0]  pv_q;
  logic [3:0]  pf_q;
  logic [31:0] p_q, sqp_q, m8_q, m9_q, pb_q, pb2_q, m8b_q, pout_q;
  logic [31:0] corr;

  assign p1 = {16'b0, press_coeffs_low_i[15:0]};
  assign p2 = sx16(press_coeffs_low_i[31:16]);
  assign p3 = sx16(press_coeffs_low_i[47:32]);
  assign p4 = sx16(press_coeffs_low_i[63:48]);
  assign p5 = sx16(press_coeffs_high_i[15:0]);
  assign p6 = sx16(press_coeffs_high_i[31:16]);
  assign p7 = sx16(press_coeffs_high_i[47:32]);
  assign p8 = sx16(press_coeffs_high_i[63:48]);
  assign p9 = sx16(p9_raw_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
      pv_q  <= '0;
    end else begin
      vld_q <= {vld_q[5:0], valid_i};
      pv_q  <= {pv_q[2:0], side_out.valid};
    end
  end

  always_ff @(posedge clk_i) begin
    pa_q    <= sra32(fine_i, 1) - PressFineOffset;
    rp_q[0] <= raw_pressure_i;
    for (int i = 1; i < 4; i++) begin
      rp_q[i] <= rp_q[i-1];
    end
    sq_q  <= sra32(pa_q, 2) * sra32(pa_q, 2);
    m5_q  <= pa_q * p5;
    m2_q  <= p2 * pa_q;
    b1_q  <= sra32(sq_q, 11) * p6;
    m3_q  <= p3 * sra32(sq_q, 13);
    m5b_q <= m5_q;
    m2b_q <= m2_q;
    b_q   <= sra32(b1_q + (m5b_q << 1), 2) + (p4 << 16);
    aa_q  <= sra32(sra32(m3_q, 3) + sra32(m2b_q, 1), 18);
    m1_q  <= (32'd32768 + aa_q) * p1;
    pre_q <= (PressRawBase - {12'b0, rp_q[3]}) - sra32(b_q, 12);
    dv_q  <= sra32(m1_q, 15);
    num_q <= pre_q * PressScale;
    // small numerators are doubled before the divide, large ones after
    dvd_q <= num_q[31] ? num_q : (num_q << 1);
    dbl_q <= num_q[31];
    flt_q <= (dv_q == '0);
    dvs_q <= dv_q;
  end

  assign side_in = '{valid: vld_q[6], dbl: dbl_q, fault: flt_q};

  esc_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .dividend_i (dvd_q),
    .divisor_i  (dvs_q),
    .side_i     (side_in),
    .quot_o     (quot),
    .side_o     (side_out)
  );

  assign corr = sra32(sra32(m9_q, 12) + sra32(m8b_q, 13) + p7, 4);

  always_ff @(posedge clk_i) begin
    p_q     <= side_out.dbl ? (quot << 1) : quot;
    pf_q    <= {pf_q[2:0], side_out.fault};
    sqp_q   <= (p_q >> 3) * (p_q >> 3);
    m8_q    <= (p_q >> 2) * p8;
    pb_q    <= p_q;
    m9_q    <= p9 * (sqp_q >> 13);
    m8b_q   <= m8_q;
    pb2_q   <= pb_q;
    pout_q  <= pf_q[2] ? '0 : (pb2_q + corr);
  end

  assign valid_o    = pv_q[3];
  assign pressure_o = pout_q;
  assign fault_o    = pf_q[3];

endmodule

// ----- sv/esc_humid.sv -----
// humidity path from fine temperature, clamped and scaled to 1/1024 percent
// depends on esc_pkg
module esc_humid import esc_pkg::*; (
  input  logic        clk_i,
  input  logic [31:0] fine_i,
  input  logic [15:0] raw_humidity_i,
  input  logic [31:0] humid_hi_i,
  input  logic [31:0] humid_coeffs_i,
  output logic [16:0] humidity_o
);

  logic [31:0] h1, h2, h3, h4, h5, h6;
  logic [31:0] mh5_q, mh6_q, mh3_q, a_q, a2_q, m_q, m2_q;
  logic [31:0] x_q, x2_q, x3_q, dd_q, m3_q, r;
  logic [15:0] rh_q;
  logic [16:0] hum_q;

  // humid_hi: H1 [7:0], H2 [23:8], H3 [31:24] of the upper register slice
  assign h1 = {24'b0, humid_hi_i[7:0]};
  assign h2 = sx16(humid_hi_i[23:8]);
  assign h3 = {24'b0, humid_hi_i[31:24]};
  assign h4 = {{20{humid_coeffs_i[11]}}, humid_coeffs_i[11:0]};
  assign h5 = {{20{humid_coeffs_i[23]}}, humid_coeffs_i[23:12]};
  assign h6 = {{24{humid_coeffs_i[31]}}, humid_coeffs_i[31:24]};

  always_ff @(posedge clk_i) begin
    rh_q  <= raw_humidity_i;
    mh5_q <= h5 * (fine_i - HumFineOffset);
    mh6_q <= (fine_i - HumFineOffset) * h6;
    mh3_q <= (fine_i - HumFineOffset) * h3;
    a_q   <= sra32((({16'b0, rh_q} << 14) - (h4 << 20) - mh5_q) + 32'd16384, 15);
    m_q   <= sra32(mh6_q, 10) * (sra32(mh3_q, 11) + 32'd32768);
    m2_q  <= (sra32(m_q, 10) + 32'd2097152) * h2;
    a2_q  <= a_q;
    x_q   <= a2_q * sra32(m2_q + 32'd8192, 14);
    dd_q  <= sra32(x_q, 15) * sra32(x_q, 15);
    x2_q  <= x_q;
    m3_q  <= sra32(dd_q, 7) * h1;
    x3_q  <= x2_q;
    hum_q <= r[28:12];
  end

  always_comb begin
    r = x3_q - sra32(m3_q, 4);
    if (r[31]) begin
      r = '0;
    end else if (r > HumClampMax) begin
      r = HumClampMax;
    end
  end

  assign humidity_o = hum_q;

endmodule
